// ----- hdl/rat_pkg.sv -----
// Shared types, constants and lookup functions for the road arc travel time unit.
// Used by the CORDIC cell, the square root cell and the top level.
// No dependencies.
`default_nettype none

package rat_pkg;

  localparam int LANES              = 4;
  localparam int XY_W               = 34;
  localparam int Z_W                = 33;
  localparam int SQRT_STEPS         = 32;
  localparam int CORDIC_STAGES_DEF  = 24;

  // Road class codes.
  localparam logic [3:0] RC_MOTORWAY     = 4'd0;
  localparam logic [3:0] RC_TRUNK        = 4'd1;
  localparam logic [3:0] RC_PRIMARY      = 4'd2;
  localparam logic [3:0] RC_SECONDARY    = 4'd3;
  localparam logic [3:0] RC_TERTIARY     = 4'd4;
  localparam logic [3:0] RC_UNCLASSIFIED = 4'd5;

  // Angle conversion: q = floor((m * 2^24 + ANG_HALF) / ANG_DEN).
  localparam logic [23:0] ANG_DEN        = 24'd14062500;
  localparam logic [23:0] ANG_HALF       = 24'd7031250;
  localparam logic [25:0] ANG_DEN2       = 26'd28125000;
  localparam logic [25:0] ANG_DEN3       = 26'd42187500;
  localparam logic [63:0] ANG_RECIP_FULL = (64'd1 << 56) / 64'd14062500;
  localparam logic [32:0] ANG_RECIP      = ANG_RECIP_FULL[32:0];

  localparam logic [XY_W-1:0] CORDIC_GAIN = 34'd652032874;

  // Travel time scaling.
  localparam logic [31:0] TIME_NUM = 32'd1245703125;
  localparam logic [63:0] TIME_NUM_SH = 64'd1245703125 << 32;
  localparam logic [63:0] DEN_65 = 64'd91553792 * 64'd65;
  localparam logic [63:0] DEN_55 = 64'd91553792 * 64'd55;
  localparam logic [63:0] DEN_45 = 64'd91553792 * 64'd45;
  localparam logic [63:0] DEN_35 = 64'd91553792 * 64'd35;
  localparam logic [63:0] DEN_25 = 64'd91553792 * 64'd25;
  localparam logic [63:0] RECIP_65 = TIME_NUM_SH / DEN_65;
  localparam logic [63:0] RECIP_55 = TIME_NUM_SH / DEN_55;
  localparam logic [63:0] RECIP_45 = TIME_NUM_SH / DEN_45;
  localparam logic [63:0] RECIP_35 = TIME_NUM_SH / DEN_35;
  localparam logic [63:0] RECIP_25 = TIME_NUM_SH / DEN_25;

  typedef enum logic [2:0] {SPD_65, SPD_55, SPD_45, SPD_35, SPD_25} speed_t;
  typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_t;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0]  z;
    quad_t           quad;
  } cordic_lane_t;

  typedef struct packed {
    logic                           valid;
    speed_t                         speed;
    cordic_lane_t [LANES-1:0]       lane;
  } cordic_bus_t;

  typedef struct packed {
    logic        valid;
    speed_t      speed;
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_bus_t;

  function automatic speed_t class_speed(input logic [3:0] cls);
    speed_t s;
    case (cls)
      RC_MOTORWAY:                             s = SPD_65;
      RC_TRUNK, RC_PRIMARY, RC_UNCLASSIFIED:   s = SPD_55;
      RC_SECONDARY:                            s = SPD_45;
      RC_TERTIARY:                             s = SPD_35;
      default:                                 s = SPD_25;
    endcase
    return s;
  endfunction

  function automatic logic [33:0] speed_den(input speed_t s);
    logic [33:0] d;
    case (s)
      SPD_65:  d = DEN_65[33:0];
      SPD_55:  d = DEN_55[33:0];
      SPD_45:  d = DEN_45[33:0];
      SPD_35:  d = DEN_35[33:0];
      default: d = DEN_25[33:0];
    endcase
    return d;
  endfunction

  function automatic logic [31:0] speed_recip(input speed_t s);
    logic [31:0] r;
    case (s)
      SPD_65:  r = RECIP_65[31:0];
      SPD_55:  r = RECIP_55[31:0];
      SPD_45:  r = RECIP_45[31:0];
      SPD_35:  r = RECIP_35[31:0];
      default: r = RECIP_25[31:0];
    endcase
    return r;
  endfunction

  // Arctangent of 2^-idx in binary angle units (2^32 per turn).
  function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rat_cordic_cell.sv -----
// One CORDIC rotation step for the four angle lanes, registered.
// Depends on rat_pkg.
`default_nettype none

module rat_cordic_cell
  import rat_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cordic_bus_t din,
  output cordic_bus_t dout
);

  logic signed [XY_W-1:0] xs [LANES];
  logic signed [XY_W-1:0] ys [LANES];
  logic signed [Z_W-1:0]  zs [LANES];
  logic signed [Z_W-1:0]  at;
  cordic_lane_t [LANES-1:0] lane_next;
  cordic_lane_t [LANES-1:0] lane_q;
  speed_t                   speed_q;
  logic                     valid_q;

  always_comb begin
    at = $signed({1'b0, cordic_atan(5'(STAGE))});
    for (int l = 0; l < LANES; l++) begin
      xs[l] = $signed(din.lane[l].x);
      ys[l] = $signed(din.lane[l].y);
      zs[l] = $signed(din.lane[l].z);
      lane_next[l].quad = din.lane[l].quad;
      if (!zs[l][Z_W-1]) begin
        lane_next[l].x = xs[l] - (ys[l] >>> STAGE);
        lane_next[l].y = ys[l] + (xs[l] >>> STAGE);
        lane_next[l].z = zs[l] - at;
      end else begin
        lane_next[l].x = xs[l] + (ys[l] >>> STAGE);
        lane_next[l].y = ys[l] - (xs[l] >>> STAGE);
        lane_next[l].z = zs[l] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_q  <= lane_next;
      speed_q <= din.speed;
    end
  end

  assign dout = '{valid: valid_q, speed: speed_q, lane: lane_q};

endmodule

`default_nettype wire

// ----- hdl/rat_sqrt_cell.sv -----
// One digit step of the integer square root, two radicand bits per item, registered.
// Depends on rat_pkg.
`default_nettype none

module rat_sqrt_cell
  import rat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  sqrt_bus_t din,
  output sqrt_bus_t dout
);

  logic [35:0] rem2;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] diff;
  logic        valid_q;
  speed_t      speed_q;
  logic [63:0] v_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;

  always_comb begin
    rem2  = {din.rem, din.v[63:62]};
    trial = {2'b00, din.root, 2'b01};
    ge    = rem2 >= trial;
    diff  = rem2 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed_q <= din.speed;
      v_q     <= {din.v[61:0], 2'b00};
      rem_q   <= ge ? diff[33:0] : rem2[33:0];
      root_q  <= {din.root[30:0], ge};
    end
  end

  assign dout = '{valid: valid_q, speed: speed_q, v: v_q, rem: rem_q, root: root_q};

endmodule

`default_nettype wire

// ----- hdl/road_arc_travel_time_unit.sv -----
// Top level of the road arc travel time unit: angle conversion, CORDIC chain,
// chord and square root chain, speed scaling. Depends on rat_pkg, rat_cordic_cell
// and rat_sqrt_cell.
//
//  channel | direction | tdata                                  | tuser
//  s_*     | in        | src_lat, src_lon, dst_lat, dst_lon    | road_class
//  m_*     | out       | travel_time                            | -
//
// One item enters per cycle while s_tready is high; each passes through the four angle
// stages, the CORDIC cell chain, six vector stages, the 32 square root cells and three
// scaling stages.
// Reset is synchronous and clears only the valid bits of the pipeline.
// When a result waits at the output, the whole pipeline holds and s_tready drops.
`default_nettype none

module road_arc_travel_time_unit
  import rat_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // src_lat[30:0], src_lon[62:31], dst_lat[93:63], dst_lon[125:94]
  input  logic [3:0]   s_tuser,  // road_class
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata   // travel_time
);

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Angle conversion stages.
  logic signed [31:0] coord [LANES];
  logic [31:0]        mag   [LANES];
  logic               a1_valid, a2_valid, a3_valid, a4_valid;
  speed_t             a1_speed, a2_speed, a3_speed, a4_speed;
  logic [63:0]        a1_prod [LANES];
  logic [31:0]        a1_mag  [LANES];
  logic               a1_neg  [LANES];
  logic [31:0]        qe      [LANES];
  logic [31:0]        a2_qe   [LANES];
  logic [55:0]        a2_qd   [LANES];
  logic [55:0]        a2_num  [LANES];
  logic               a2_neg  [LANES];
  logic [25:0]        ang_r   [LANES];
  logic [31:0]        ang_q   [LANES];
  logic               ang_res_ok;
  logic [31:0]        a3_ang  [LANES];
  logic [31:0]        qsum    [LANES];
  logic [31:0]        dres    [LANES];
  cordic_lane_t [LANES-1:0] lane_init;
  cordic_lane_t [LANES-1:0] a4_lane;

  always_comb begin
    coord[0] = {s_tdata[30], s_tdata[30:0]};
    coord[1] = s_tdata[62:31];
    coord[2] = {s_tdata[93], s_tdata[93:63]};
    coord[3] = s_tdata[125:94];
    for (int l = 0; l < LANES; l++) begin
      mag[l] = coord[l][31] ? 32'(-coord[l]) : coord[l];
      qe[l]  = a1_prod[l][63:32];
    end
  end

  always_comb begin
    ang_res_ok = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      ang_r[l] = 26'(a2_num[l] - a2_qd[l]);
      if (ang_r[l] >= ANG_DEN2) begin
        ang_q[l] = a2_qe[l] + 32'd2;
      end else if (ang_r[l] >= {2'b00, ANG_DEN}) begin
        ang_q[l] = a2_qe[l] + 32'd1;
      end else begin
        ang_q[l] = a2_qe[l];
      end
      if (ang_r[l] >= ANG_DEN3) begin
        ang_res_ok = 1'b0;
      end
    end
  end

  // Quadrant from the rounded top angle bits, residual into the first cell.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qsum[l]           = a3_ang[l] + 32'h4000_0000;
      dres[l]           = a3_ang[l] - {qsum[l][31:30], 30'd0};
      lane_init[l].x    = CORDIC_GAIN;
      lane_init[l].y    = '0;
      lane_init[l].z    = {dres[l][31], dres[l]};
      lane_init[l].quad = quad_t'(qsum[l][31:30]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
      a2_valid <= 1'b0;
      a3_valid <= 1'b0;
      a4_valid <= 1'b0;
    end else if (adv) begin
      a1_valid <= s_tvalid;
      a2_valid <= a1_valid;
      a3_valid <= a2_valid;
      a4_valid <= a3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_speed <= class_speed(s_tuser);
      a2_speed <= a1_speed;
      a3_speed <= a2_speed;
      a4_speed <= a3_speed;
      a4_lane  <= lane_init;
      for (int l = 0; l < LANES; l++) begin
        a1_prod[l] <= {32'd0, mag[l]} * {31'd0, ANG_RECIP};
        a1_mag[l]  <= mag[l];
        a1_neg[l]  <= coord[l][31];
        a2_qe[l]   <= qe[l];
        a2_qd[l]   <= {24'd0, qe[l]} * {32'd0, ANG_DEN};
        a2_num[l]  <= {a1_mag[l], 24'd0} + {32'd0, ANG_HALF};
        a2_neg[l]  <= a1_neg[l];
        a3_ang[l]  <= a2_neg[l] ? 32'd0 - ang_q[l] : ang_q[l];
      end
    end
  end

  // CORDIC chain.
  cordic_bus_t cbus [CORDIC_STAGES+1];
  assign cbus[0] = '{valid: a4_valid, speed: a4_speed, lane: a4_lane};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    rat_cordic_cell #(.STAGE(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (cbus[i]),
      .dout (cbus[i+1])
    );
  end

  // Vector and chord stages.
  logic signed [XY_W-1:0] fx [LANES];
  logic signed [XY_W-1:0] fy [LANES];
  logic signed [31:0]     co [LANES];
  logic signed [31:0]     si [LANES];
  logic                   v0_valid, v1_valid, v2_valid, v3_valid, v4_valid, v5_valid;
  speed_t                 v0_speed, v1_speed, v2_speed, v3_speed, v4_speed, v5_speed;
  logic signed [31:0]     v0_co [LANES];
  logic signed [31:0]     v0_si [LANES];
  logic signed [63:0]     v1_p  [LANES];
  logic signed [31:0]     v1_za, v1_zb;
  logic signed [31:0]     v2_a  [3];
  logic signed [31:0]     v2_b  [3];
  logic signed [32:0]     diff  [3];
  logic [31:0]            dmag  [3];
  logic [31:0]            v3_mag [3];
  logic [63:0]            v4_sq  [3];
  logic [63:0]            v5_sum;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fx[l] = $signed(cbus[CORDIC_STAGES].lane[l].x);
      fy[l] = $signed(cbus[CORDIC_STAGES].lane[l].y);
      case (cbus[CORDIC_STAGES].lane[l].quad)
        QUAD_0: begin
          co[l] = 32'(fx[l]);
          si[l] = 32'(fy[l]);
        end
        QUAD_90: begin
          co[l] = 32'(-fy[l]);
          si[l] = 32'(fx[l]);
        end
        QUAD_180: begin
          co[l] = 32'(-fx[l]);
          si[l] = 32'(-fy[l]);
        end
        default: begin
          co[l] = 32'(fy[l]);
          si[l] = 32'(-fx[l]);
        end
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      diff[k] = 33'(v2_b[k]) - 33'(v2_a[k]);
      dmag[k] = diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0_valid <= 1'b0;
      v1_valid <= 1'b0;
      v2_valid <= 1'b0;
      v3_valid <= 1'b0;
      v4_valid <= 1'b0;
      v5_valid <= 1'b0;
    end else if (adv) begin
      v0_valid <= cbus[CORDIC_STAGES].valid;
      v1_valid <= v0_valid;
      v2_valid <= v1_valid;
      v3_valid <= v2_valid;
      v4_valid <= v3_valid;
      v5_valid <= v4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v0_speed <= cbus[CORDIC_STAGES].speed;
      v1_speed <= v0_speed;
      v2_speed <= v1_speed;
      v3_speed <= v2_speed;
      v4_speed <= v3_speed;
      v5_speed <= v4_speed;
      for (int l = 0; l < LANES; l++) begin
        v0_co[l] <= co[l];
        v0_si[l] <= si[l];
      end
      // Lanes: source latitude, source longitude, destination latitude, longitude.
      v1_p[0] <= v0_co[0] * v0_co[1];
      v1_p[1] <= v0_co[0] * v0_si[1];
      v1_p[2] <= v0_co[2] * v0_co[3];
      v1_p[3] <= v0_co[2] * v0_si[3];
      v1_za   <= v0_si[0];
      v1_zb   <= v0_si[2];
      v2_a[0] <= 32'((v1_p[0] + 64'sd536870912) >>> 30);
      v2_a[1] <= 32'((v1_p[1] + 64'sd536870912) >>> 30);
      v2_a[2] <= v1_za;
      v2_b[0] <= 32'((v1_p[2] + 64'sd536870912) >>> 30);
      v2_b[1] <= 32'((v1_p[3] + 64'sd536870912) >>> 30);
      v2_b[2] <= v1_zb;
      for (int k = 0; k < 3; k++) begin
        v3_mag[k] <= dmag[k];
        v4_sq[k]  <= {32'd0, v3_mag[k]} * {32'd0, v3_mag[k]};
      end
      v5_sum <= v4_sq[0] + v4_sq[1] + v4_sq[2];
    end
  end

  // Square root chain.
  sqrt_bus_t sbus [SQRT_STEPS+1];
  assign sbus[0] = '{valid: v5_valid, speed: v5_speed, v: v5_sum, rem: '0, root: '0};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    rat_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (sbus[j]),
      .dout (sbus[j+1])
    );
  end

  // Scaling: estimate by reciprocal, then one correction step.
  logic [33:0] den_sel;
  logic        t1_valid, t2_valid;
  logic [63:0] t1_prod, t1_num;
  logic [33:0] t1_den, t2_den;
  logic [31:0] te;
  logic [31:0] t2_te;
  logic [63:0] t2_num, t2_qd;
  logic [35:0] t_res;
  logic [32:0] tsum;

  always_comb begin
    den_sel = speed_den(sbus[SQRT_STEPS].speed);
    te      = 32'((t1_prod + 64'h8000_0000) >> 32);
    t_res   = 36'(t2_num - t2_qd);
    tsum    = {1'b0, t2_te} + {32'd0, (t_res >= {2'b00, t2_den})};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      t1_valid <= sbus[SQRT_STEPS].valid;
      t2_valid <= t1_valid;
      m_tvalid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_prod <= {32'd0, sbus[SQRT_STEPS].root}
                 * {32'd0, speed_recip(sbus[SQRT_STEPS].speed)};
      t1_num  <= {32'd0, sbus[SQRT_STEPS].root} * {32'd0, TIME_NUM}
                 + {31'd0, den_sel[33:1]};
      t1_den  <= den_sel;
      t2_te   <= te;
      t2_qd   <= {32'd0, te} * {30'd0, t1_den};
      t2_num  <= t1_num;
      t2_den  <= t1_den;
      m_tdata <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    end
  end

  // The reciprocal estimates must never be off by more than the correction covers.
  assert property (@(posedge clk) disable iff (rst) a2_valid |-> ang_res_ok)
    else $error("angle quotient estimate out of correction range");

  assert property (@(posedge clk) disable iff (rst)
    t2_valid |-> (t_res < {1'b0, t2_den, 1'b0}))
    else $error("time quotient estimate out of correction range");

  // A held result must freeze the input side in the same cycle.
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while the output is stalled");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for road_arc_travel_time_unit: directed table then random
// arcs, each checked against its row's time or a local fixed-point chord/CORDIC model.
// Depends on rat_pkg and the RTL of the unit.
`default_nettype none

module testbench
  import rat_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  N_RANDOM    = 1800;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  LATENCY     = CORDIC_STAGES_DEF + 45;

  typedef struct {
    logic signed [30:0] src_lat;
    logic signed [31:0] src_lon;
    logic signed [30:0] dst_lat;
    logic signed [31:0] dst_lon;
    logic [3:0]         road_class;
    bit                 typed;     // expected travel time given in the row
    logic [31:0]        travel_time;
  } arc_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;

  // Expected results in order of acceptance; the counters wrap with the store.
  logic [31:0] expected_times [0:2047];
  logic [10:0] exp_wr = '0;
  logic [10:0] exp_rd = '0;
  int          failures = 0;
  int          arcs_sent = 0;
  int          cycles = 0;

  road_arc_travel_time_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // Arctangent of 2^-i in binary angle units.
  localparam longint ATAN_BA [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  function automatic logic [63:0] class_mph(input logic [3:0] cls);
    case (cls)
      RC_MOTORWAY:                           return 64'd65;
      RC_TRUNK, RC_PRIMARY, RC_UNCLASSIFIED: return 64'd55;
      RC_SECONDARY:                          return 64'd45;
      RC_TERTIARY:                           return 64'd35;
      default:                               return 64'd25;
    endcase
  endfunction

  // Coordinate in 1e-7 degree to binary angle, rounded half away from zero.
  function automatic logic [31:0] coord_angle(input longint c);
    logic [63:0] mag;
    logic [63:0] q;
    logic [31:0] a;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    q = ((mag << 32) + 64'd1800000000) / 64'd3600000000;
    a = q[31:0];
    if (c < 0) a = -a;
    return a;
  endfunction

  task automatic angle_sincos(input logic [31:0] a, output longint co, output longint si);
    logic [31:0] quad;
    logic [31:0] resid;
    longint      z, x, y, nx;
    quad = ((a + 32'h40000000) >> 30) & 32'd3;
    resid = a - (quad << 30);
    z = longint'(signed'(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_BA[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_BA[i];
      end
      x = nx;
    end
    case (quad[1:0])
      2'd0:    begin co = x;  si = y;  end
      2'd1:    begin co = -y; si = x;  end
      2'd2:    begin co = -x; si = -y; end
      default: begin co = y;  si = -x; end
    endcase
  endtask

  task automatic unit_vector(input longint lat, input longint lon, output longint v[3]);
    longint cp, sp, cl, sl;
    angle_sincos(coord_angle(lat), cp, sp);
    angle_sincos(coord_angle(lon), cl, sl);
    v[0] = (cp * cl + (64'sd1 <<< 29)) >>> 30;
    v[1] = (cp * sl + (64'sd1 <<< 29)) >>> 30;
    v[2] = sp;
  endtask

  function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
    logic [63:0] rem, root, b;
    rem = val;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  task automatic arc_travel_time(input arc_t arc, output logic [31:0] tt);
    longint      va[3], vb[3], d;
    logic [63:0] sum, mag, chord, den, t;
    unit_vector(longint'(arc.src_lat), longint'(arc.src_lon), va);
    unit_vector(longint'(arc.dst_lat), longint'(arc.dst_lon), vb);
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d = vb[k] - va[k];
      mag = (d < 0) ? 64'(-d) : 64'(d);
      sum = sum + mag * mag;
    end
    chord = floor_sqrt(sum);
    den = 64'd91553792 * class_mph(arc.road_class);
    t = (chord * 64'd1245703125 + den / 2) / den;
    tt = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
  endtask

  localparam int N_DIRECTED = 20;
  arc_t directed_arcs [0:N_DIRECTED-1] = '{
    // Identical end points give zero time for every class, unknown ones included.
    '{0, 0, 0, 0, 4'd0, 1, 0},
    '{900000000, 1800000000, 900000000, 1800000000, 4'd1, 1, 0},
    '{-900000000, -1800000000, -900000000, -1800000000, 4'd2, 1, 0},
    '{31'h3FFFFFFF, 32'h7FFFFFFF, 31'h3FFFFFFF, 32'h7FFFFFFF, 4'd3, 1, 0},
    '{31'h40000000, 32'h80000000, 31'h40000000, 32'h80000000, 4'd4, 1, 0},
    '{123456789, -98765432, 123456789, -98765432, 4'd5, 1, 0},
    '{-1, -1, -1, -1, 4'd6, 1, 0},
    '{1, 1, 1, 1, 4'd7, 1, 0},
    '{450000000, 900000000, 450000000, 900000000, 4'd8, 1, 0},
    '{-450000000, 0, -450000000, 0, 4'd9, 1, 0},
    '{0, 1800000000, 0, 1800000000, 4'd15, 1, 0},
    '{900000000, 0, -900000000, 0, 4'd0, 0, 0},
    '{-900000000, -1800000000, 900000000, 1800000000, 4'd4, 0, 0},
    '{31'h3FFFFFFF, 0, 31'h40000000, 0, 4'd1, 0, 0},
    '{0, 32'h7FFFFFFF, 0, 32'h80000000, 4'd2, 0, 0},
    '{0, 0, 0, 1800000000, 4'd6, 0, 0},
    '{0, 0, 0, 900000000, 4'd12, 0, 0},
    '{0, 0, 1, 1, 4'd3, 0, 0},
    '{-1, -1, 1, 1, 4'd14, 0, 0},
    '{515000000, -1200000, 515001234, -1187654, 4'd5, 0, 0}
  };

  function automatic logic signed [31:0] in_range(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic arc_t random_arc();
    arc_t a;
    int   kind;
    kind = $urandom_range(0, 9);
    a.typed = 0;
    a.travel_time = 0;
    a.road_class = 4'($urandom_range(0, 15));
    if (kind < 5) begin
      // A realistic short arc: destination close to the source.
      a.src_lat = 31'(in_range(899000000));
      a.src_lon = in_range(1800000000);
      a.dst_lat = 31'(a.src_lat + in_range(50000));
      a.dst_lon = a.src_lon + in_range(50000);
    end else if (kind < 8) begin
      a.src_lat = 31'(in_range(900000000));
      a.src_lon = in_range(1800000000);
      a.dst_lat = 31'(in_range(900000000));
      a.dst_lon = in_range(1800000000);
    end else begin
      a.src_lat = 31'($urandom());
      a.src_lon = $urandom();
      a.dst_lat = 31'($urandom());
      a.dst_lon = $urandom();
    end
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_arc(input arc_t arc, input bit calm);
    logic [31:0] tt;
    int          gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, arc.dst_lon, arc.dst_lat, arc.src_lon, arc.src_lat};
    s_tuser  <= arc.road_class;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (arc.typed) tt = arc.travel_time;
    else arc_travel_time(arc, tt);
    expected_times[exp_wr] = tt;
    exp_wr = exp_wr + 11'd1;
    arcs_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off to fill the pipeline.
  initial begin
    int  stall;
    bit  held;
    stall = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && arcs_sent >= 600) begin
        held = 1;
        stall = 400;
      end else if (stall == 0 && (cycles % 1000) >= 200) begin
        case ($urandom_range(0, 49))
          0, 1, 2, 3, 4: stall = $urandom_range(1, 3);
          5:             stall = $urandom_range(10, 40);
          default:       stall = 0;
        endcase
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (exp_rd == exp_wr) begin
        $error("travel_time result with no item outstanding: actual %0d", m_tdata);
        failures++;
      end else begin
        if (m_tdata !== expected_times[exp_rd]) begin
          $error("travel_time mismatch: expected %0d, actual %0d",
                 expected_times[exp_rd], m_tdata);
          failures++;
        end
        exp_rd = exp_rd + 11'd1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) send_arc(directed_arcs[i], 1'b0);
    for (int i = 0; i < N_RANDOM; i++) send_arc(random_arc(), (i % 300) < 60);
    s_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (failures == 0 && exp_rd == exp_wr) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
